// File: rtl/core/fifo_free_list_slot_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the free-list slot allocator
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FIFO_FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FIFO_FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FFLSA_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FFLSA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/core/fflsa_pkg.sv
// ---------------------------------------------------------------------------
// Free-list slot allocator package
// Sizes, operation and status codes, controller states and the result word.
// ---------------------------------------------------------------------------
package fflsa_pkg;

	localparam int SLOTS = 1024;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

	typedef enum logic [1:0] {
		OP_RESERVE     = 2'd0,
		OP_RELEASE     = 2'd1,
		OP_RELEASE_ALL = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_SLOT = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP
	} state_t;

	// Packed from the top bit down; the output word places granted_slot lowest.
	typedef struct packed {
		logic [CNT_W-1:0] live_slots;
		status_t          status;
		logic [IDX_W-1:0] granted_slot;
	} result_t;

endpackage

// File: rtl/core/fflsa_ram.sv
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fflsa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/fflsa_out_stage.sv
// ---------------------------------------------------------------------------
// Result output register
// Holds one finished result word until the downstream side takes it.
// ---------------------------------------------------------------------------
module fflsa_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fflsa_pkg::result_t push_res,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata     // granted_slot[9:0], status[11:10], live_slots[22:12]
);

	logic              valid_q;
	fflsa_pkg::result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= push_res;
		end
	end

endmodule

// File: rtl/core/fifo_free_list_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// Free-list slot allocator
// Hands out and takes back fixed-size slot indices through a FIFO free list.
// ---------------------------------------------------------------------------
// Every input word gives exactly one result word. A reserve or a single
// release runs as follows: the word is accepted and the free-list memories
// are read at the head slot or at the released slot; then, once the output
// register is free, the result is committed and the memories are written
// back. The next word is accepted only after that commit, so a new word is
// never taken while the last one is still in work. A release-all walks every
// slot issued so far, one slot per cycle, in these steps: the accept, one
// mark read per issued slot, the handling of the last returning mark, a step
// to let the sweep drain, and the commit. Slots that were never issued are
// never swept and their marks are never used, so the memories need no
// clearing pass after reset and the block is ready as soon as reset is
// released. A finished result waits in an output register; a new word may be
// accepted while it waits.
// ---------------------------------------------------------------------------
module fifo_free_list_slot_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // opcode[1:0], slot_index[11:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata      // granted_slot[9:0], status[11:10], live_slots[22:12]
);

	localparam int IDX_W = fflsa_pkg::IDX_W;
	localparam int CNT_W = fflsa_pkg::CNT_W;

	// Controller state and free-list bookkeeping.
	fflsa_pkg::state_t state_q, state_d;
	logic [1:0]        op_q, op_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  tail_q, tail_d;
	logic              list_empty_q, list_empty_d;
	logic [CNT_W-1:0]  hw_q, hw_d;
	logic [CNT_W-1:0]  live_q, live_d;

	// Release-all sweep: the read index and the slot whose mark returns now.
	logic [CNT_W-1:0]  sweep_q, sweep_d;
	logic              pend_s1, pend_d;
	logic [IDX_W-1:0]  pend_idx_s1, pend_idx_d;

	// Memory ports. The mark store holds one bit per slot (set while the slot
	// sits in the free list); the link store holds each free slot's successor.
	logic [IDX_W-1:0]  rd_addr;
	logic              mark_we;
	logic [IDX_W-1:0]  mark_waddr;
	logic              mark_wdata;
	logic              mark_rdata;
	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;
	logic [IDX_W-1:0]  link_wdata;
	logic [IDX_W-1:0]  link_rdata;

	// Append of a slot at the tail of the free list, shared by the single
	// release and the sweep.
	logic              append_en;
	logic [IDX_W-1:0]  append_idx;

	logic               push;
	fflsa_pkg::result_t push_res;
	logic               out_free;

	logic              in_accept;
	logic [1:0]        in_opcode;
	logic [IDX_W-1:0]  in_slot;

	assign in_opcode = s_tdata[1:0];
	assign in_slot   = s_tdata[IDX_W+1:2];
	assign s_tready  = (state_q == fflsa_pkg::ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	fflsa_ram #(
		.DEPTH(fflsa_pkg::SLOTS),
		.WIDTH(1)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(rd_addr),
		.rdata(mark_rdata)
	);

	fflsa_ram #(
		.DEPTH(fflsa_pkg::SLOTS),
		.WIDTH(IDX_W)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rd_addr),
		.rdata(link_rdata)
	);

	fflsa_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_res(push_res),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fflsa_pkg::ST_IDLE;
			op_q         <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			list_empty_q <= 1'b1;
			hw_q         <= '0;
			live_q       <= '0;
			sweep_q      <= '0;
			pend_s1      <= 1'b0;
			pend_idx_s1  <= '0;
		end else begin
			state_q      <= state_d;
			op_q         <= op_d;
			idx_q        <= idx_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			list_empty_q <= list_empty_d;
			hw_q         <= hw_d;
			live_q       <= live_d;
			sweep_q      <= sweep_d;
			pend_s1      <= pend_d;
			pend_idx_s1  <= pend_idx_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		idx_d        = idx_q;
		head_d       = head_q;
		tail_d       = tail_q;
		list_empty_d = list_empty_q;
		hw_d         = hw_q;
		live_d       = live_q;
		sweep_d      = sweep_q;
		pend_d       = 1'b0;
		pend_idx_d   = pend_idx_s1;
		mark_we      = 1'b0;
		mark_waddr   = '0;
		mark_wdata   = 1'b0;
		link_we      = 1'b0;
		link_waddr   = '0;
		link_wdata   = '0;
		append_en    = 1'b0;
		append_idx   = '0;
		push         = 1'b0;
		push_res     = '0;

		// A reserve looks at the head slot, a release at the named slot.
		if (op_q == fflsa_pkg::OP_RESERVE) begin
			rd_addr = head_q;
		end else begin
			rd_addr = idx_q;
		end

		case (state_q)
			fflsa_pkg::ST_IDLE: begin
				if (in_opcode == fflsa_pkg::OP_RESERVE) begin
					rd_addr = head_q;
				end else begin
					rd_addr = in_slot;
				end
				if (in_accept) begin
					op_d    = in_opcode;
					idx_d   = in_slot;
					sweep_d = '0;
					if (in_opcode == fflsa_pkg::OP_RELEASE_ALL) begin
						state_d = fflsa_pkg::ST_SWEEP;
					end else begin
						state_d = fflsa_pkg::ST_EXEC;
					end
				end
			end

			fflsa_pkg::ST_SWEEP: begin
				// Issue one mark read per cycle and act on the one that returns.
				rd_addr = sweep_q[IDX_W-1:0];
				if (sweep_q < hw_q) begin
					sweep_d    = sweep_q + 1'b1;
					pend_d     = 1'b1;
					pend_idx_d = sweep_q[IDX_W-1:0];
				end else if (!pend_s1) begin
					state_d = fflsa_pkg::ST_EXEC;
				end
				if (pend_s1 && !mark_rdata) begin
					append_en  = 1'b1;
					append_idx = pend_idx_s1;
				end
			end

			fflsa_pkg::ST_EXEC: begin
				// The read data for this word is valid here; commit once the
				// output register can take the result.
				if (out_free) begin
					push    = 1'b1;
					state_d = fflsa_pkg::ST_IDLE;
					push_res.status = fflsa_pkg::STATUS_OK;
					case (op_q)
						fflsa_pkg::OP_RESERVE: begin
							if (!list_empty_q) begin
								push_res.granted_slot = head_q;
								mark_we    = 1'b1;
								mark_waddr = head_q;
								mark_wdata = 1'b0;
								if (head_q == tail_q) begin
									list_empty_d = 1'b1;
								end else begin
									head_d = link_rdata;
								end
								live_d = live_q + 1'b1;
							end else if (hw_q < fflsa_pkg::SLOTS_CNT) begin
								push_res.granted_slot = hw_q[IDX_W-1:0];
								mark_we    = 1'b1;
								mark_waddr = hw_q[IDX_W-1:0];
								mark_wdata = 1'b0;
								hw_d       = hw_q + 1'b1;
								live_d     = live_q + 1'b1;
							end else begin
								push_res.status = fflsa_pkg::STATUS_FULL;
							end
						end
						fflsa_pkg::OP_RELEASE: begin
							if ((CNT_W'(idx_q) < hw_q) && !mark_rdata) begin
								append_en  = 1'b1;
								append_idx = idx_q;
								if (live_q != '0) begin
									live_d = live_q - 1'b1;
								end
							end else begin
								push_res.status = fflsa_pkg::STATUS_BAD_SLOT;
							end
						end
						fflsa_pkg::OP_RELEASE_ALL: begin
							live_d = '0;
						end
						default: begin
							push_res.status = fflsa_pkg::STATUS_BAD_SLOT;
						end
					endcase
					push_res.live_slots = live_d;
				end
			end

			default: begin
				state_d = fflsa_pkg::ST_IDLE;
			end
		endcase

		// The tail's link is written only when the list already holds a slot;
		// the end of the list is known from the tail register, not a marker.
		if (append_en) begin
			mark_we      = 1'b1;
			mark_waddr   = append_idx;
			mark_wdata   = 1'b1;
			if (!list_empty_q) begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = append_idx;
			end else begin
				head_d = append_idx;
			end
			tail_d       = append_idx;
			list_empty_d = 1'b0;
		end
	end

`include "fifo_free_list_slot_allocator_unit_macros.svh"

	`FFLSA_ASSERT_IMPL(a_live_within_issued, clk, arst_n, 1'b1, live_q <= hw_q, "live count exceeds issued slots")
	`FFLSA_ASSERT_IMPL(a_full_only_when_exhausted, clk, arst_n, m_tvalid && (m_tdata[11:10] == fflsa_pkg::STATUS_FULL), hw_q == fflsa_pkg::SLOTS_CNT, "full reported before all slots issued")
	`FFLSA_ASSERT_IMPL(a_sweep_bounded, clk, arst_n, state_q == fflsa_pkg::ST_SWEEP, sweep_q <= hw_q, "sweep ran past issued slots")
	`FFLSA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, s_tvalid && s_tready, state_q != fflsa_pkg::ST_IDLE, "accepted word did not start work")

endmodule

// File: tb/sv/tb_fifo_free_list_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// Testbench for the free-list slot allocator
// Drives reserve, release, release-all and unused-code words into the slave stream,
// predicts each result word from a behavioral copy of the free list, and
// compares every word leaving the master stream against that prediction.
// ---------------------------------------------------------------------------
module tb_fifo_free_list_slot_allocator_unit;

	import fflsa_pkg::*;

	// The package names only the three defined operations; code 3 is unused.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Longest run of cycles with no word moving on either side. It must outlast
	// a release-all over every slot and the long receiver hold-off, and leaves
	// a wide margin over both.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;     // opcode[1:0], slot_index[11:2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // granted_slot[9:0], status[11:10], live_slots[22:12]

	// Idle rates in percent for the sender and the receiver.
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	// A nonzero value asks the receiver process to hold off for that many cycles.
	int hold_req  = 0;
	int hold_left = 0;

	int stall_cycles   = 0;
	int mismatch_count = 0;

	// Predicted result words, oldest first.
	result_t pending_results[$];

	// Behavioral copy of the allocator state.
	int pred_link [SLOTS];
	bit pred_free [SLOTS];
	int pred_head;
	int pred_tail;
	int pred_high_water;
	int pred_live;

	fifo_free_list_slot_allocator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// -----------------------------------------------------------------------
	// Prediction
	// -----------------------------------------------------------------------

	// Links a live slot onto the tail of the free list and drops the live count.
	function automatic void free_slot_tail(input int s);
		pred_link[s] = SLOTS;
		pred_free[s] = 1'b1;
		if (pred_tail < SLOTS) begin
			pred_link[pred_tail] = s;
		end
		pred_tail = s;
		if (pred_head >= SLOTS) begin
			pred_head = s;
		end
		if (pred_live > 0) begin
			pred_live--;
		end
	endfunction

	// Applies one accepted word to the state copy and returns its result word.
	function automatic result_t predict_slot_result(input logic [1:0] op,
			input logic [IDX_W-1:0] idx);
		result_t r;
		int      s;
		r = '0;
		r.status = STATUS_OK;
		case (op)
			OP_RESERVE: begin
				if (pred_head < SLOTS) begin
					// Reuse the oldest released slot.
					s = pred_head;
					r.granted_slot = IDX_W'(s);
					pred_free[s] = 1'b0;
					if (pred_link[s] >= SLOTS) begin
						pred_head = SLOTS;
						pred_tail = SLOTS;
					end else begin
						pred_head = pred_link[s];
					end
					pred_live++;
				end else if (pred_high_water < SLOTS) begin
					// Free list empty: issue a slot that was never used.
					r.granted_slot = IDX_W'(pred_high_water);
					pred_free[pred_high_water] = 1'b0;
					pred_high_water++;
					pred_live++;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			OP_RELEASE: begin
				if (int'(idx) >= pred_high_water || pred_free[idx]) begin
					r.status = STATUS_BAD_SLOT;
				end else begin
					free_slot_tail(int'(idx));
				end
			end
			OP_RELEASE_ALL: begin
				for (int i = 0; i < pred_high_water; i++) begin
					if (!pred_free[i]) begin
						free_slot_tail(i);
					end
				end
				pred_live = 0;
			end
			default: begin
				r.status = STATUS_BAD_SLOT;
			end
		endcase
		r.live_slots = CNT_W'(pred_live);
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Sender
	// -----------------------------------------------------------------------

	// Offers one word after a random gap and waits for the block to take it.
	// Valid is not lowered after the handshake, so back-to-back words keep it
	// high; a gap in the next call or the end of the stimulus lowers it.
	task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] idx);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, idx, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_slot_result(op, idx));
	endtask

	// -----------------------------------------------------------------------
	// Receiver, result checker and watchdog
	// -----------------------------------------------------------------------

	// Handshake values are read right after the edge, before any register
	// update of that edge lands, so they are the values the block saw.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[22:0]);
				if (pending_results.size() == 0) begin
					$display("%0t: result word with nothing expected: %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.granted_slot !== want.granted_slot) begin
						$display("%0t: granted_slot expected %0d got %0d",
							$time, want.granted_slot, got.granted_slot);
						mismatch_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, got.status);
						mismatch_count++;
					end
					if (got.live_slots !== want.live_slots) begin
						$display("%0t: live_slots expected %0d got %0d",
							$time, want.live_slots, got.live_slots);
						mismatch_count++;
					end
					if (m_tdata[23] !== 1'b0) begin
						$display("%0t: pad bit expected 0 got %b", $time, m_tdata[23]);
						mismatch_count++;
					end
				end
			end

			// A requested hold-off takes precedence over random stalls.
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Short hand-written sequence: empty release-all, a never-issued release at
	// the top index, a double release, FIFO reuse order, the unused opcode and
	// a release-all with both live and free slots present.
	task automatic test_directed_cases();
		send_word(OP_RELEASE_ALL, '0);
		send_word(OP_RESERVE, '1);
		send_word(OP_RELEASE, 10'd1023);
		send_word(OP_RELEASE, 10'd0);
		send_word(OP_RELEASE, 10'd0);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		send_word(OP_RELEASE, 10'd2);
		send_word(OP_RELEASE, 10'd1);
		send_word(OP_RELEASE, 10'd3);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		send_word(OP_UNUSED, 10'd1023);
		send_word(OP_UNUSED, 10'd0);
		send_word(OP_RELEASE, 10'd512);
		send_word(OP_RELEASE_ALL, 10'd1023);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		send_word(OP_RELEASE_ALL, '0);
	endtask

	// Mostly well-formed traffic: reserves and releases of live slots, with a
	// share of releases at random indices, rare release-alls and unused codes.
	task automatic test_random_traffic(input int count);
		int          pick;
		logic [IDX_W-1:0] idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			idx  = IDX_W'($urandom);
			if (pick < 45) begin
				send_word(OP_RESERVE, idx);
			end else if (pick < 78) begin
				// Aim at a live slot; a few tries are enough most of the time.
				if (pred_high_water > 0) begin
					for (int k = 0; k < 4; k++) begin
						idx = IDX_W'($urandom_range(pred_high_water - 1));
						if (!pred_free[idx]) begin
							break;
						end
					end
				end
				send_word(OP_RELEASE, idx);
			end else if (pick < 93) begin
				send_word(OP_RELEASE, idx);
			end else if (pick < 97) begin
				send_word(OP_RELEASE_ALL, idx);
			end else begin
				send_word(OP_UNUSED, idx);
			end
		end
	endtask

	// The receiver stops for a long stretch while the sender keeps offering
	// words back to back, so the output register fills and input stalls.
	task automatic test_backpressure_fill();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_req       = 400;
		for (int n = 0; n < 30; n++) begin
			send_word(($urandom_range(2) == 0) ? OP_RELEASE : OP_RESERVE,
				IDX_W'($urandom_range(pred_high_water)));
		end
	endtask

	// Issues every slot, runs into the full condition, returns the top slot and
	// takes it again, then frees everything.
	task automatic test_allocator_full();
		send_word(OP_RELEASE_ALL, '0);
		while (pred_head != SLOTS || pred_high_water != SLOTS) begin
			send_word(OP_RESERVE, IDX_W'($urandom));
		end
		repeat (3) send_word(OP_RESERVE, IDX_W'($urandom));
		send_word(OP_RELEASE, 10'd1023);
		send_word(OP_RESERVE, '0);
		send_word(OP_RESERVE, '0);
		repeat (20) send_word(OP_RELEASE, IDX_W'($urandom));
		send_word(OP_RELEASE_ALL, '1);
	endtask

	// -----------------------------------------------------------------------
	// Run
	// -----------------------------------------------------------------------

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			pred_link[i] = SLOTS;
			pred_free[i] = 1'b0;
		end
		pred_head       = SLOTS;
		pred_tail       = SLOTS;
		pred_high_water = 0;
		pred_live       = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();

		// Random traffic under each idle pattern in turn.
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_traffic(150);
		src_idle_pct   = 87;
		sink_stall_pct = 0;
		test_random_traffic(150);
		src_idle_pct   = 0;
		sink_stall_pct = 87;
		test_random_traffic(150);
		src_idle_pct   = 13;
		sink_stall_pct = 13;
		test_random_traffic(150);

		test_backpressure_fill();

		src_idle_pct   = 13;
		sink_stall_pct = 13;
		test_allocator_full();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
